// ----- hdl/atlv_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the application packet TLV parser.
// Depends on nothing; every other file of the block uses it by scoped names.
package atlv_pkg;

	localparam int SizeWidth = 32;
	localparam int QueueDepth = 4;
	localparam int QueuePtrW = $clog2(QueueDepth);
	localparam int PosWidth = 17;
	localparam logic [PosWidth-1:0] PosMax = '1;

	localparam logic [7:0] PackStart = 8'd2;
	localparam logic [7:0] PackEnd = 8'd3;
	localparam logic [7:0] PackTypeSize = 8'd0;
	localparam logic [7:0] PackTypeName = 8'd1;

	typedef logic [SizeWidth-1:0] size_t;
	typedef logic [PosWidth-1:0] pos_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD   = 2'd0,
		KIND_NAME      = 2'd1,
		KIND_SUMMARY   = 2'd2,
		KIND_TRUNCATED = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		PH_TYPE  = 2'd0,
		PH_LEN   = 2'd1,
		PH_VALUE = 2'd2
	} phase_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  out_byte;
		logic [7:0]  seq_number;
		logic [31:0] size_value;
		logic        size_found;
		logic        is_end_packet;
		logic        last_of_run;
	} result_t;

	// One queue entry carries the one or two results caused by one request.
	typedef struct packed {
		result_t first;
		result_t second;
		logic    has_second;
	} entry_t;

endpackage

// ----- hdl/app_packet_tlv_parser.sv -----
`timescale 1ns / 1ps
// Top level of the application packet TLV parser: front end, entry queue, back end.
// Depends on atlv_pkg, atlv_front, atlv_queue and atlv_back.
//
//  Channel  Handshake             Payload
//  packet   pkt_valid, pkt_stall  pkt_byte, last_byte
//  result   res_valid, res_stall  kind, out_byte, seq_number, size_value,
//                                 size_found, is_end_packet, last_of_run
//
// One byte is accepted per cycle while pkt_stall is low; its state update happens in the cycle of acceptance.
// A byte causes zero, one or two results; results leave at one per cycle from the output
// register while res_stall is low, so the two results of one byte leave one after the other.
// A four-entry queue parts the front end from the back end; pkt_stall rises only when it is full.
// Reset clears all packet and field state; no clearing pass is needed.
module app_packet_tlv_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pkt_valid,
	output logic        pkt_stall,
	input  logic [7:0]  pkt_byte,
	input  logic        last_byte,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [1:0]  kind,
	output logic [7:0]  out_byte,
	output logic [7:0]  seq_number,
	output logic [31:0] size_value,
	output logic        size_found,
	output logic        is_end_packet,
	output logic        last_of_run
);

	logic              take;
	logic              push;
	logic              full;
	logic              q_valid;
	logic              q_pop;
	atlv_pkg::entry_t  wr_entry;
	atlv_pkg::entry_t  rd_entry;
	atlv_pkg::result_t res;

	assign pkt_stall = full;
	assign take = pkt_valid && !full;

	atlv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.pkt_byte  (pkt_byte),
		.last_byte (last_byte),
		.push      (push),
		.entry     (wr_entry)
	);

	atlv_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (push),
		.wr_data  (wr_entry),
		.full     (full),
		.rd_valid (q_valid),
		.rd_pop   (q_pop),
		.rd_data  (rd_entry)
	);

	atlv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (rd_entry),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	assign kind = res.kind;
	assign out_byte = res.out_byte;
	assign seq_number = res.seq_number;
	assign size_value = res.size_value;
	assign size_found = res.size_found;
	assign is_end_packet = res.is_end_packet;
	assign last_of_run = res.last_of_run;

endmodule

// ----- hdl/atlv_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts packet bytes, tracks packet and field state, and forms queue entries.
// Depends on atlv_pkg.
module atlv_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic [7:0]         pkt_byte,
	input  logic               last_byte,
	output logic               push,
	output atlv_pkg::entry_t   entry
);

	atlv_pkg::pos_t   pos_q;
	logic             ctrl_q;
	logic             end_q;
	logic [7:0]       seq_q;
	logic [15:0]      len_q;
	atlv_pkg::phase_t phase_q;
	logic [7:0]       ftype_q;
	logic [7:0]       rem_q;
	atlv_pkg::size_t  acc_q;
	logic             size_done_q;
	logic             name_done_q;
	logic             seen_q;

	atlv_pkg::pos_t   nxt_pos;
	logic             nxt_ctrl;
	logic             nxt_end;
	logic [7:0]       nxt_seq;
	logic [15:0]      nxt_len;
	atlv_pkg::phase_t nxt_phase;
	logic [7:0]       nxt_ftype;
	logic [7:0]       nxt_rem;
	atlv_pkg::size_t  nxt_acc;
	logic             nxt_size_done;
	logic             nxt_name_done;
	logic             nxt_seen;

	atlv_pkg::result_t res_a;
	atlv_pkg::result_t res_b;
	logic              a_valid;
	logic              b_valid;

	always_comb begin
		atlv_pkg::pos_t idx;
		logic           final_byte;
		logic           complete;

		nxt_pos = pos_q;
		nxt_ctrl = ctrl_q;
		nxt_end = end_q;
		nxt_seq = seq_q;
		nxt_len = len_q;
		nxt_phase = phase_q;
		nxt_ftype = ftype_q;
		nxt_rem = rem_q;
		nxt_acc = acc_q;
		nxt_size_done = size_done_q;
		nxt_name_done = name_done_q;
		nxt_seen = seen_q;
		res_a = '0;
		res_b = '0;
		a_valid = 1'b0;
		b_valid = 1'b0;
		idx = pos_q - atlv_pkg::PosWidth'(4);
		final_byte = (rem_q == 8'd1);
		complete = 1'b0;

		if (pos_q == '0) begin
			nxt_ctrl = (pkt_byte == atlv_pkg::PackStart) || (pkt_byte == atlv_pkg::PackEnd);
			nxt_end = (pkt_byte == atlv_pkg::PackEnd);
			nxt_phase = atlv_pkg::PH_TYPE;
			nxt_ftype = '0;
			nxt_rem = '0;
			nxt_acc = '0;
			nxt_size_done = 1'b0;
			nxt_name_done = 1'b0;
			nxt_seq = '0;
			nxt_len = '0;
			if (nxt_ctrl) begin
				nxt_seen = 1'b1;
			end
		end else if (ctrl_q) begin
			unique case (phase_q)
				atlv_pkg::PH_LEN: begin
					nxt_rem = pkt_byte;
					if (pkt_byte == 8'd0) begin
						if (ftype_q == atlv_pkg::PackTypeSize) begin
							nxt_size_done = 1'b1;
						end
						if (ftype_q == atlv_pkg::PackTypeName) begin
							nxt_name_done = 1'b1;
						end
						nxt_phase = atlv_pkg::PH_TYPE;
					end else begin
						nxt_phase = atlv_pkg::PH_VALUE;
					end
				end
				atlv_pkg::PH_VALUE: begin
					if (ftype_q == atlv_pkg::PackTypeSize && !size_done_q) begin
						nxt_acc = (acc_q << 8) | atlv_pkg::size_t'(pkt_byte);
						if (final_byte) begin
							nxt_size_done = 1'b1;
						end
					end
					if (ftype_q == atlv_pkg::PackTypeName && !name_done_q) begin
						a_valid = 1'b1;
						res_a.kind = atlv_pkg::KIND_NAME;
						res_a.out_byte = pkt_byte;
						res_a.last_of_run = final_byte;
						if (final_byte) begin
							nxt_name_done = 1'b1;
						end
					end
					nxt_rem = rem_q - 8'd1;
					if (nxt_rem == 8'd0) begin
						nxt_phase = atlv_pkg::PH_TYPE;
					end
				end
				default: begin
					nxt_ftype = pkt_byte;
					nxt_phase = atlv_pkg::PH_LEN;
				end
			endcase
		end else if (seen_q) begin
			if (pos_q == atlv_pkg::PosWidth'(1)) begin
				nxt_seq = pkt_byte;
			end else if (pos_q == atlv_pkg::PosWidth'(2)) begin
				nxt_len = {pkt_byte, 8'd0};
			end else if (pos_q == atlv_pkg::PosWidth'(3)) begin
				nxt_len = {len_q[15:8], pkt_byte};
			end else if (idx < atlv_pkg::PosWidth'(len_q)) begin
				a_valid = 1'b1;
				res_a.kind = atlv_pkg::KIND_PAYLOAD;
				res_a.out_byte = pkt_byte;
				res_a.seq_number = seq_q;
				res_a.last_of_run = ((idx + atlv_pkg::PosWidth'(1)) == atlv_pkg::PosWidth'(len_q));
			end
		end

		if (last_byte) begin
			if (nxt_ctrl) begin
				b_valid = 1'b1;
				res_b.kind = atlv_pkg::KIND_SUMMARY;
				res_b.size_value = nxt_size_done ? 32'(nxt_acc) : 32'd0;
				res_b.size_found = nxt_size_done;
				res_b.is_end_packet = nxt_end;
			end else if (nxt_seen) begin
				complete = (pos_q >= atlv_pkg::PosWidth'(3)) &&
					((18'(pos_q) + 18'd1) >= (18'(nxt_len) + 18'd4));
				if (!complete) begin
					b_valid = 1'b1;
					res_b.kind = atlv_pkg::KIND_TRUNCATED;
					res_b.seq_number = nxt_seq;
				end
			end
			nxt_pos = '0;
		end else if (pos_q < atlv_pkg::PosMax) begin
			nxt_pos = pos_q + atlv_pkg::PosWidth'(1);
		end
	end

	always_comb begin
		push = take && (a_valid || b_valid);
		entry = '0;
		if (a_valid) begin
			entry.first = res_a;
			entry.second = res_b;
			entry.has_second = b_valid;
		end else begin
			entry.first = res_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			ctrl_q <= 1'b0;
			end_q <= 1'b0;
			seq_q <= '0;
			len_q <= '0;
			phase_q <= atlv_pkg::PH_TYPE;
			ftype_q <= '0;
			rem_q <= '0;
			acc_q <= '0;
			size_done_q <= 1'b0;
			name_done_q <= 1'b0;
			seen_q <= 1'b0;
		end else if (take) begin
			pos_q <= nxt_pos;
			ctrl_q <= nxt_ctrl;
			end_q <= nxt_end;
			seq_q <= nxt_seq;
			len_q <= nxt_len;
			phase_q <= nxt_phase;
			ftype_q <= nxt_ftype;
			rem_q <= nxt_rem;
			acc_q <= nxt_acc;
			size_done_q <= nxt_size_done;
			name_done_q <= nxt_name_done;
			seen_q <= nxt_seen;
		end
	end

endmodule

// ----- hdl/atlv_queue.sv -----
`timescale 1ns / 1ps
// Short first-in first-out queue of result entries between front and back end.
// Depends on atlv_pkg.
module atlv_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  atlv_pkg::entry_t wr_data,
	output logic             full,
	output logic             rd_valid,
	input  logic             rd_pop,
	output atlv_pkg::entry_t rd_data
);

	atlv_pkg::entry_t                 mem_q [atlv_pkg::QueueDepth];
	logic [atlv_pkg::QueuePtrW-1:0]   wr_ptr_q;
	logic [atlv_pkg::QueuePtrW-1:0]   rd_ptr_q;
	logic [atlv_pkg::QueuePtrW:0]     count_q;
	logic                             do_pop;

	assign full = (count_q == (atlv_pkg::QueuePtrW + 1)'(atlv_pkg::QueueDepth));
	assign rd_valid = (count_q != '0);
	assign rd_data = mem_q[rd_ptr_q];
	assign do_pop = rd_pop && rd_valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + atlv_pkg::QueuePtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + atlv_pkg::QueuePtrW'(1);
			end
			if (wr_en && !do_pop) begin
				count_q <= count_q + (atlv_pkg::QueuePtrW + 1)'(1);
			end else if (!wr_en && do_pop) begin
				count_q <= count_q - (atlv_pkg::QueuePtrW + 1)'(1);
			end
		end
	end

endmodule

// ----- hdl/atlv_back.sv -----
`timescale 1ns / 1ps
// Back end: splits queue entries into single results and holds the output register.
// Depends on atlv_pkg.
module atlv_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  atlv_pkg::entry_t   q_data,
	output logic               q_pop,
	output logic               res_valid,
	input  logic               res_stall,
	output atlv_pkg::result_t  res
);

	logic              out_valid_q;
	atlv_pkg::result_t out_q;
	logic              sec_valid_q;
	atlv_pkg::result_t sec_q;
	logic              slot_free;

	assign slot_free = !out_valid_q || !res_stall;
	assign q_pop = slot_free && !sec_valid_q && q_valid;
	assign res_valid = out_valid_q;
	assign res = out_q;

	always_ff @(posedge clk) begin
		if (slot_free) begin
			if (sec_valid_q) begin
				out_q <= sec_q;
			end else if (q_valid) begin
				out_q <= q_data.first;
				sec_q <= q_data.second;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sec_valid_q <= 1'b0;
		end else if (slot_free) begin
			if (sec_valid_q) begin
				out_valid_q <= 1'b1;
				sec_valid_q <= 1'b0;
			end else if (q_valid) begin
				out_valid_q <= 1'b1;
				sec_valid_q <= q_data.has_second;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Testbench for app_packet_tlv_parser: directed and random packets with a tracking scoreboard.
// Depends on atlv_pkg for the result layout, the kind codes and the packet constants.
module tb;

	localparam int QuietLimit = 2000;
	localparam int RandomBytes = 1350;

	class tlv_tracker;
		atlv_pkg::pos_t    position;
		logic              in_control;
		logic              in_end_pkt;
		logic              control_seen;
		logic [7:0]        seq_held;
		logic [15:0]       length_declared;
		atlv_pkg::phase_t  phase;
		logic [7:0]        ftype;
		logic [7:0]        fremain;
		atlv_pkg::size_t   size_acc;
		logic              size_ok;
		logic              name_ok;
		atlv_pkg::result_t expected_results[$];
		int                failures;

		function new();
			position = '0;
			in_control = 1'b0;
			in_end_pkt = 1'b0;
			control_seen = 1'b0;
			seq_held = '0;
			length_declared = '0;
			phase = atlv_pkg::PH_TYPE;
			ftype = '0;
			fremain = '0;
			size_acc = '0;
			size_ok = 1'b0;
			name_ok = 1'b0;
			failures = 0;
		endfunction

		function void push_result(atlv_pkg::kind_t k, logic [7:0] ob, logic [7:0] sq,
				logic [31:0] fs, logic sf, logic ep, logic lr);
			atlv_pkg::result_t r;
			r.kind = k;
			r.out_byte = ob;
			r.seq_number = sq;
			r.size_value = fs;
			r.size_found = sf;
			r.is_end_packet = ep;
			r.last_of_run = lr;
			expected_results.push_back(r);
		endfunction

		// Advances the parser state by one accepted request and queues what it must produce.
		function void take_byte(logic [7:0] b, logic fin);
			logic at_end;
			int idx;
			if (position == '0) begin
				in_control = (b == atlv_pkg::PackStart) || (b == atlv_pkg::PackEnd);
				in_end_pkt = (b == atlv_pkg::PackEnd);
				phase = atlv_pkg::PH_TYPE;
				ftype = '0;
				fremain = '0;
				size_acc = '0;
				size_ok = 1'b0;
				name_ok = 1'b0;
				seq_held = '0;
				length_declared = '0;
				if (in_control)
					control_seen = 1'b1;
			end else if (in_control) begin
				case (phase)
					atlv_pkg::PH_LEN: begin
						fremain = b;
						if (b == 8'd0) begin
							if (ftype == atlv_pkg::PackTypeSize)
								size_ok = 1'b1;
							if (ftype == atlv_pkg::PackTypeName)
								name_ok = 1'b1;
							phase = atlv_pkg::PH_TYPE;
						end else begin
							phase = atlv_pkg::PH_VALUE;
						end
					end
					atlv_pkg::PH_VALUE: begin
						at_end = (fremain == 8'd1);
						if (ftype == atlv_pkg::PackTypeSize && !size_ok) begin
							size_acc = {size_acc[atlv_pkg::SizeWidth-9:0], b};
							if (at_end)
								size_ok = 1'b1;
						end
						if (ftype == atlv_pkg::PackTypeName && !name_ok) begin
							push_result(atlv_pkg::KIND_NAME, b, 8'h00, '0, 1'b0, 1'b0, at_end);
							if (at_end)
								name_ok = 1'b1;
						end
						fremain = fremain - 8'd1;
						if (fremain == 8'd0)
							phase = atlv_pkg::PH_TYPE;
					end
					default: begin
						ftype = b;
						phase = atlv_pkg::PH_LEN;
					end
				endcase
			end else if (control_seen) begin
				if (position == atlv_pkg::pos_t'(1)) begin
					seq_held = b;
				end else if (position == atlv_pkg::pos_t'(2)) begin
					length_declared = {b, 8'h00};
				end else if (position == atlv_pkg::pos_t'(3)) begin
					length_declared[7:0] = b;
				end else begin
					idx = int'(position) - 4;
					if (idx < int'(length_declared))
						push_result(atlv_pkg::KIND_PAYLOAD, b, seq_held, '0, 1'b0, 1'b0,
							idx + 1 == int'(length_declared));
				end
			end
			if (fin) begin
				if (in_control) begin
					push_result(atlv_pkg::KIND_SUMMARY, 8'h00, 8'h00,
						size_ok ? size_acc : '0, size_ok, in_end_pkt, 1'b0);
				end else if (control_seen) begin
					if (!(int'(position) >= 3 &&
							int'(position) + 1 >= 4 + int'(length_declared)))
						push_result(atlv_pkg::KIND_TRUNCATED, 8'h00, seq_held, '0,
							1'b0, 1'b0, 1'b0);
				end
				position = '0;
			end else if (position != atlv_pkg::PosMax) begin
				position = position + 1'b1;
			end
		endfunction

		function string show(atlv_pkg::result_t r);
			return $sformatf("kind %0d byte %02h seq %02h size %08h found %b end %b last %b",
				r.kind, r.out_byte, r.seq_number, r.size_value, r.size_found,
				r.is_end_packet, r.last_of_run);
		endfunction

		function void flag(string msg);
			if (failures < 10)
				$display("%s", msg);
			failures++;
		endfunction

		function void match_result(atlv_pkg::result_t got);
			atlv_pkg::result_t want;
			if (expected_results.size() == 0) begin
				flag({"unexpected result: ", show(got)});
			end else begin
				want = expected_results.pop_front();
				if (got !== want)
					flag({"result mismatch: expected ", show(want), " got ", show(got)});
			end
		endfunction

		function int outstanding();
			return expected_results.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        pkt_valid;
	logic        pkt_stall;
	logic [7:0]  pkt_byte;
	logic        last_byte;
	logic        res_valid;
	logic        res_stall;
	logic [1:0]  kind;
	logic [7:0]  out_byte;
	logic [7:0]  seq_number;
	logic [31:0] size_value;
	logic        size_found;
	logic        is_end_packet;
	logic        last_of_run;

	logic        calm;
	int          quiet_cycles;
	logic [7:0]  pkt_bytes[$];
	tlv_tracker  board = new();

	app_packet_tlv_parser uut (
		.clk(clk),
		.arst_n(arst_n),
		.pkt_valid(pkt_valid),
		.pkt_stall(pkt_stall),
		.pkt_byte(pkt_byte),
		.last_byte(last_byte),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.kind(kind),
		.out_byte(out_byte),
		.seq_number(seq_number),
		.size_value(size_value),
		.size_found(size_found),
		.is_end_packet(is_end_packet),
		.last_of_run(last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(negedge clk) begin
		res_stall <= !calm && ($urandom_range(99) < 38);
	end

	always @(posedge clk) begin
		atlv_pkg::result_t got;
		if (arst_n && res_valid && !res_stall) begin
			got.kind = atlv_pkg::kind_t'(kind);
			got.out_byte = out_byte;
			got.seq_number = seq_number;
			got.size_value = size_value;
			got.size_found = size_found;
			got.is_end_packet = is_end_packet;
			got.last_of_run = last_of_run;
			board.match_result(got);
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else begin
			if ((pkt_valid && !pkt_stall) || (res_valid && !res_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QuietLimit) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic fin);
		while (!calm && $urandom_range(99) < 38) begin
			pkt_valid <= 1'b0;
			@(negedge clk);
		end
		pkt_valid <= 1'b1;
		pkt_byte <= b;
		last_byte <= fin;
		do @(posedge clk); while (pkt_stall);
		board.take_byte(b, fin);
		@(negedge clk);
	endtask

	task automatic send_packet();
		for (int i = 0; i < pkt_bytes.size(); i++)
			send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
		pkt_bytes.delete();
	endtask

	initial begin
		int sent;
		int nf;
		int len;
		int n;
		int decl;
		int cut;
		logic [7:0] b0;
		logic [7:0] t;

		arst_n = 1'b0;
		pkt_valid = 1'b0;
		pkt_byte = 8'h00;
		last_byte = 1'b0;
		calm = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// A data packet before any control packet must vanish.
		pkt_bytes = '{8'h00, 8'h01, 8'h00};
		send_packet();
		// Full-scale size, then a name whose final byte closes the packet.
		pkt_bytes = '{atlv_pkg::PackStart, atlv_pkg::PackTypeSize, 8'd4,
			8'hFF, 8'hFF, 8'hFF, 8'hFF, atlv_pkg::PackTypeName, 8'd2, 8'h41, 8'h80};
		send_packet();
		// Data packet with one byte beyond its declared payload.
		pkt_bytes = '{8'h07, 8'h55, 8'h00, 8'h01, 8'hFF, 8'h11};
		send_packet();
		// Short data packet: its one payload byte and the truncation flag come together.
		pkt_bytes = '{8'h09, 8'h01, 8'h00, 8'h02, 8'hEE};
		send_packet();
		// End packet with an empty name and a size field cut off by the packet end.
		pkt_bytes = '{atlv_pkg::PackEnd, atlv_pkg::PackTypeName, 8'd0,
			atlv_pkg::PackTypeSize, 8'd3, 8'h05};
		send_packet();
		// Empty size field and a name cut off by the packet end.
		pkt_bytes = '{atlv_pkg::PackStart, atlv_pkg::PackTypeSize, 8'd0,
			atlv_pkg::PackTypeName, 8'd3, 8'h41};
		send_packet();

		sent = 0;
		while (sent < RandomBytes) begin
			calm = (sent >= 500 && sent < 800);
			n = $urandom_range(19);
			if (n < 9) begin
				pkt_bytes.push_back($urandom_range(1) ? atlv_pkg::PackEnd : atlv_pkg::PackStart);
				nf = $urandom_range(4);
				repeat (nf) begin
					case ($urandom_range(9))
						0, 1, 2, 3: t = atlv_pkg::PackTypeSize;
						4, 5, 6, 7: t = atlv_pkg::PackTypeName;
						default: t = 8'($urandom_range(255));
					endcase
					len = ($urandom_range(29) == 0) ? $urandom_range(255) : $urandom_range(9);
					pkt_bytes.push_back(t);
					pkt_bytes.push_back(8'(len));
					repeat (len) pkt_bytes.push_back(8'($urandom_range(255)));
				end
				if ($urandom_range(6) == 0) begin
					cut = $urandom_range(pkt_bytes.size(), 1);
					while (pkt_bytes.size() > cut)
						void'(pkt_bytes.pop_back());
				end
			end else if (n < 18) begin
				do b0 = 8'($urandom_range(255));
				while (b0 == atlv_pkg::PackStart || b0 == atlv_pkg::PackEnd);
				pkt_bytes.push_back(b0);
				case ($urandom_range(9))
					0: begin
						decl = $urandom_range(16'hFFFF);
						pkt_bytes.push_back(8'($urandom_range(255)));
						pkt_bytes.push_back(8'(decl >> 8));
						pkt_bytes.push_back(8'(decl));
						repeat ($urandom_range(3)) pkt_bytes.push_back(8'($urandom_range(255)));
					end
					1: begin
						repeat ($urandom_range(2)) pkt_bytes.push_back(8'($urandom_range(255)));
					end
					default: begin
						decl = ($urandom_range(14) == 0) ? $urandom_range(300) : $urandom_range(12);
						pkt_bytes.push_back(8'($urandom_range(255)));
						pkt_bytes.push_back(8'(decl >> 8));
						pkt_bytes.push_back(8'(decl));
						case ($urandom_range(9))
							0, 1: len = $urandom_range(decl);
							2: len = decl + $urandom_range(4, 1);
							default: len = decl;
						endcase
						repeat (len) pkt_bytes.push_back(8'($urandom_range(255)));
					end
				endcase
			end else begin
				repeat ($urandom_range(8, 1)) pkt_bytes.push_back(8'($urandom_range(255)));
			end
			sent += pkt_bytes.size();
			send_packet();
		end
		calm = 1'b0;
		pkt_valid <= 1'b0;

		while (board.outstanding() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (board.failures == 0 && board.outstanding() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

// ----- filelist.f -----
hdl/atlv_pkg.sv
hdl/atlv_front.sv
hdl/atlv_queue.sv
hdl/atlv_back.sv
hdl/app_packet_tlv_parser.sv
bench/tb.sv
